// File: hw/rtl/pspr_pkg.sv
`default_nettype none

package pspr_pkg;

   // Field widths
   localparam int COORD_W  = 24;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int DEV_W    = 20;
   localparam int DEV2_W   = 2 * DEV_W;
   localparam int LEN2_W   = 2 * DIFF_W;
   localparam int CR_W     = 2 * DIFF_W + 1;
   localparam int MAG_W    = 2 * DIFF_W;

   // Shared multiplier: signed 27 x 27, wide products built from 26-bit halves.
   localparam int HALF_W   = 26;
   localparam int WIDE_W   = 2 * HALF_W;
   localparam int MUL_W    = HALF_W + 1;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ACC_W    = 2 * WIDE_W;

   localparam int MAX_POINTS_DEF = 64;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [DEV_W-1:0] DEV_RESET = DEV_W'(100);
   localparam logic REG_MAX_DEVIATION = 1'b0;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_DEV,
      MUL_BXX,
      MUL_BYY,
      MUL_DXBY,
      MUL_DYBX,
      MUL_LIM_LL,
      MUL_LIM_LH,
      MUL_LIM_HL,
      MUL_LIM_HH,
      MUL_MAG_LL,
      MUL_MAG_LH,
      MUL_MAG_HL,
      MUL_MAG_HH
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD_MID,
      ACC_ADD_TOP
   } acc_op_type;

   typedef enum logic [3:0] {
      LD_NONE,
      LD_DEV2,
      LD_CHORD,
      LD_LEN_FIRST,
      LD_LEN_ADD,
      LD_DELTA,
      LD_CR_FIRST,
      LD_CR_SUB,
      LD_MAG,
      LD_LIM,
      LD_ANCHOR,
      LD_OUT
   } ld_op_type;

   typedef struct packed {
      logic        ram_we;
      logic        ram_re;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      ld_op_type   ld_op;
      logic        out_last;
      logic        out_over;
   } pspr_cmd_type;

   typedef struct packed {
      logic zero_chord;
      logic too_far;
   } pspr_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/pspr_req_if.sv
`default_nettype none

interface pspr_req_if;
   import pspr_pkg::*;

   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      final_point;

   modport source (output valid, point_x, point_y, final_point, input ready);
   modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pspr_rsp_if.sv
`default_nettype none

interface pspr_rsp_if;
   import pspr_pkg::*;

   logic      valid;
   logic      ready;
   coord_type kept_x;
   coord_type kept_y;
   logic      last_kept;
   logic      overflowed;

   modport source (output valid, kept_x, kept_y, last_kept, overflowed, input ready);
   modport sink   (input valid, kept_x, kept_y, last_kept, overflowed, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pspr_ram.sv
`default_nettype none

module pspr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pspr_ctrl.sv
`default_nettype none

module pspr_ctrl #(
   parameter int MAX_POINTS = pspr_pkg::MAX_POINTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_final,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire pspr_pkg::pspr_status_type     status,
   output pspr_pkg::pspr_cmd_type             cmd,
   output logic [$clog2(MAX_POINTS)-1:0]      ram_addr
);
   import pspr_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [4:0] {
      S_LOAD,
      S_DEV_MUL,
      S_DEV_LD,
      S_PICK_RD,
      S_PICK_LD,
      S_EMIT,
      S_CH_RD,
      S_CH_LD,
      S_CH_SQX,
      S_CH_SQY,
      S_CH_LEN,
      S_LIM0,
      S_LIM1,
      S_LIM2,
      S_LIM3,
      S_LIM4,
      S_LIM5,
      S_PT_RD,
      S_PT_LD,
      S_CR0,
      S_CR1,
      S_CR2,
      S_MAG,
      S_SQ0,
      S_SQ1,
      S_SQ2,
      S_SQ3,
      S_SQ4,
      S_CMP
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0] last_idx;
   logic [IDX_W:0]   pick_p1_w, pick_p2_w;
   logic             out_free;
   logic             more_ends;

   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign pick_p1_w = {1'b0, pick_ff} + (IDX_W+1)'(1);
   assign pick_p2_w = {1'b0, pick_ff} + (IDX_W+1)'(2);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // Another shortcut end remains below the current one.
   assign more_ends = {1'b0, j_ff} > pick_p2_w;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      pick_in      = pick_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      ram_addr     = pick_ff;

      unique case (state_ff)
         S_LOAD: begin
            ram_addr = count_ff[IDX_W-1:0];
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  cmd.ram_we = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_final) begin
                  state_in = S_DEV_MUL;
               end
            end
         end
         S_DEV_MUL: begin
            cmd.mul_sel = MUL_DEV;
            state_in    = S_DEV_LD;
         end
         S_DEV_LD: begin
            cmd.ld_op = LD_DEV2;
            pick_in   = '0;
            state_in  = S_PICK_RD;
         end
         S_PICK_RD: begin
            cmd.ram_re = 1'b1;
            state_in   = S_PICK_LD;
         end
         S_PICK_LD: begin
            cmd.ld_op = LD_ANCHOR;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.ld_op    = LD_OUT;
               cmd.out_last = (pick_ff == last_idx);
               cmd.out_over = drop_ff;
               rsp_valid_in = 1'b1;
               if (pick_ff == last_idx) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = S_LOAD;
               end else if ({1'b0, last_idx} > pick_p1_w) begin
                  j_in     = last_idx;
                  state_in = S_CH_RD;
               end else begin
                  pick_in  = pick_p1_w[IDX_W-1:0];
                  state_in = S_PICK_RD;
               end
            end
         end
         S_CH_RD: begin
            cmd.ram_re = 1'b1;
            ram_addr   = j_ff;
            state_in   = S_CH_LD;
         end
         S_CH_LD: begin
            cmd.ld_op = LD_CHORD;
            state_in  = S_CH_SQX;
         end
         S_CH_SQX: begin
            if (status.zero_chord) begin
               if (more_ends) begin
                  j_in     = j_ff - IDX_W'(1);
                  state_in = S_CH_RD;
               end else begin
                  pick_in  = pick_p1_w[IDX_W-1:0];
                  state_in = S_PICK_RD;
               end
            end else begin
               cmd.mul_sel = MUL_BXX;
               state_in    = S_CH_SQY;
            end
         end
         S_CH_SQY: begin
            cmd.mul_sel = MUL_BYY;
            cmd.ld_op   = LD_LEN_FIRST;
            state_in    = S_CH_LEN;
         end
         S_CH_LEN: begin
            cmd.ld_op = LD_LEN_ADD;
            state_in  = S_LIM0;
         end
         S_LIM0: begin
            cmd.mul_sel = MUL_LIM_LL;
            state_in    = S_LIM1;
         end
         S_LIM1: begin
            cmd.mul_sel = MUL_LIM_LH;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_LIM2;
         end
         S_LIM2: begin
            cmd.mul_sel = MUL_LIM_HL;
            cmd.acc_op  = ACC_ADD_MID;
            state_in    = S_LIM3;
         end
         S_LIM3: begin
            cmd.mul_sel = MUL_LIM_HH;
            cmd.acc_op  = ACC_ADD_MID;
            state_in    = S_LIM4;
         end
         S_LIM4: begin
            cmd.acc_op = ACC_ADD_TOP;
            state_in   = S_LIM5;
         end
         S_LIM5: begin
            cmd.ld_op = LD_LIM;
            k_in      = pick_p1_w[IDX_W-1:0];
            state_in  = S_PT_RD;
         end
         S_PT_RD: begin
            cmd.ram_re = 1'b1;
            ram_addr   = k_ff;
            state_in   = S_PT_LD;
         end
         S_PT_LD: begin
            cmd.ld_op = LD_DELTA;
            state_in  = S_CR0;
         end
         S_CR0: begin
            cmd.mul_sel = MUL_DXBY;
            state_in    = S_CR1;
         end
         S_CR1: begin
            cmd.mul_sel = MUL_DYBX;
            cmd.ld_op   = LD_CR_FIRST;
            state_in    = S_CR2;
         end
         S_CR2: begin
            cmd.ld_op = LD_CR_SUB;
            state_in  = S_MAG;
         end
         S_MAG: begin
            cmd.ld_op = LD_MAG;
            state_in  = S_SQ0;
         end
         S_SQ0: begin
            cmd.mul_sel = MUL_MAG_LL;
            state_in    = S_SQ1;
         end
         S_SQ1: begin
            cmd.mul_sel = MUL_MAG_LH;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_SQ2;
         end
         S_SQ2: begin
            cmd.mul_sel = MUL_MAG_HL;
            cmd.acc_op  = ACC_ADD_MID;
            state_in    = S_SQ3;
         end
         S_SQ3: begin
            cmd.mul_sel = MUL_MAG_HH;
            cmd.acc_op  = ACC_ADD_MID;
            state_in    = S_SQ4;
         end
         S_SQ4: begin
            cmd.acc_op = ACC_ADD_TOP;
            state_in   = S_CMP;
         end
         S_CMP: begin
            if (status.too_far) begin
               if (more_ends) begin
                  j_in     = j_ff - IDX_W'(1);
                  state_in = S_CH_RD;
               end else begin
                  pick_in  = pick_p1_w[IDX_W-1:0];
                  state_in = S_PICK_RD;
               end
            end else if (k_ff + IDX_W'(1) == j_ff) begin
               pick_in  = j_ff;
               state_in = S_PICK_RD;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = S_PT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pick_ff <= pick_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
   end

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pspr_datapath.sv
`default_nettype none

module pspr_datapath #(
   parameter int MAX_POINTS = pspr_pkg::MAX_POINTS_DEF
) (
   input  wire logic                             clock,
   input  wire pspr_pkg::pspr_cmd_type           cmd,
   input  wire logic [$clog2(MAX_POINTS)-1:0]    ram_addr,
   input  wire pspr_pkg::coord_type              point_x,
   input  wire pspr_pkg::coord_type              point_y,
   input  wire logic [pspr_pkg::DEV_W-1:0]       max_deviation,
   output pspr_pkg::pspr_status_type             status,
   output pspr_pkg::coord_type                   kept_x,
   output pspr_pkg::coord_type                   kept_y,
   output logic                                  last_kept,
   output logic                                  overflowed
);
   import pspr_pkg::*;

   logic [2*COORD_W-1:0] rd_data;
   coord_type            rd_x, rd_y;

   coord_type            anc_x_ff, anc_y_ff;
   diff_type             bx_ff, by_ff, dx_ff, dy_ff;
   diff_type             diff_x, diff_y;
   logic [DEV2_W-1:0]    dev2_ff;
   logic [LEN2_W-1:0]    len2_ff;
   logic signed [CR_W-1:0] cr_ff;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]     acc_ff, acc_in, pp_w;
   logic [ACC_W-1:0]     lim_ff;
   logic [WIDE_W-1:0]    dev2_w, len2_w, mag_w;
   coord_type            out_x_ff, out_y_ff;
   logic                 out_last_ff, out_over_ff;

   pspr_ram #(
      .WIDTH (2 * COORD_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.ram_we),
      .wr_addr (ram_addr),
      .wr_data ({point_x, point_y}),
      .rd_en   (cmd.ram_re),
      .rd_addr (ram_addr),
      .rd_data (rd_data)
   );

   assign rd_x   = rd_data[2*COORD_W-1:COORD_W];
   assign rd_y   = rd_data[COORD_W-1:0];
   assign diff_x = {rd_x[COORD_W-1], rd_x} - {anc_x_ff[COORD_W-1], anc_x_ff};
   assign diff_y = {rd_y[COORD_W-1], rd_y} - {anc_y_ff[COORD_W-1], anc_y_ff};

   assign dev2_w = WIDE_W'(dev2_ff);
   assign len2_w = WIDE_W'(len2_ff);
   assign mag_w  = WIDE_W'(mag_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         MUL_NONE: begin
         end
         MUL_DEV: begin
            mul_a = MUL_W'(max_deviation);
            mul_b = MUL_W'(max_deviation);
         end
         MUL_BXX: begin
            mul_a = {{(MUL_W-DIFF_W){bx_ff[DIFF_W-1]}}, bx_ff};
            mul_b = {{(MUL_W-DIFF_W){bx_ff[DIFF_W-1]}}, bx_ff};
         end
         MUL_BYY: begin
            mul_a = {{(MUL_W-DIFF_W){by_ff[DIFF_W-1]}}, by_ff};
            mul_b = {{(MUL_W-DIFF_W){by_ff[DIFF_W-1]}}, by_ff};
         end
         MUL_DXBY: begin
            mul_a = {{(MUL_W-DIFF_W){dx_ff[DIFF_W-1]}}, dx_ff};
            mul_b = {{(MUL_W-DIFF_W){by_ff[DIFF_W-1]}}, by_ff};
         end
         MUL_DYBX: begin
            mul_a = {{(MUL_W-DIFF_W){dy_ff[DIFF_W-1]}}, dy_ff};
            mul_b = {{(MUL_W-DIFF_W){bx_ff[DIFF_W-1]}}, bx_ff};
         end
         MUL_LIM_LL: begin
            mul_a = {1'b0, dev2_w[HALF_W-1:0]};
            mul_b = {1'b0, len2_w[HALF_W-1:0]};
         end
         MUL_LIM_LH: begin
            mul_a = {1'b0, dev2_w[HALF_W-1:0]};
            mul_b = {1'b0, len2_w[WIDE_W-1:HALF_W]};
         end
         MUL_LIM_HL: begin
            mul_a = {1'b0, dev2_w[WIDE_W-1:HALF_W]};
            mul_b = {1'b0, len2_w[HALF_W-1:0]};
         end
         MUL_LIM_HH: begin
            mul_a = {1'b0, dev2_w[WIDE_W-1:HALF_W]};
            mul_b = {1'b0, len2_w[WIDE_W-1:HALF_W]};
         end
         MUL_MAG_LL: begin
            mul_a = {1'b0, mag_w[HALF_W-1:0]};
            mul_b = {1'b0, mag_w[HALF_W-1:0]};
         end
         MUL_MAG_LH: begin
            mul_a = {1'b0, mag_w[HALF_W-1:0]};
            mul_b = {1'b0, mag_w[WIDE_W-1:HALF_W]};
         end
         MUL_MAG_HL: begin
            mul_a = {1'b0, mag_w[WIDE_W-1:HALF_W]};
            mul_b = {1'b0, mag_w[HALF_W-1:0]};
         end
         MUL_MAG_HH: begin
            mul_a = {1'b0, mag_w[WIDE_W-1:HALF_W]};
            mul_b = {1'b0, mag_w[WIDE_W-1:HALF_W]};
         end
         default: begin
         end
      endcase
   end

   // Partial products of the wide squares are non-negative and below 2^52.
   assign pp_w = ACC_W'(prod_ff[WIDE_W-1:0]);

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD:    acc_in = pp_w;
         ACC_ADD_MID: acc_in = acc_ff + (pp_w << HALF_W);
         ACC_ADD_TOP: acc_in = acc_ff + (pp_w << WIDE_W);
         default:     acc_in = acc_ff;
      endcase
   end

   assign mag_in = cr_ff[CR_W-1] ? MAG_W'(-cr_ff) : MAG_W'(cr_ff);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
      case (cmd.ld_op)
         LD_DEV2: begin
            dev2_ff <= prod_ff[DEV2_W-1:0];
         end
         LD_CHORD: begin
            bx_ff <= diff_x;
            by_ff <= diff_y;
         end
         LD_LEN_FIRST: begin
            len2_ff <= prod_ff[LEN2_W-1:0];
         end
         LD_LEN_ADD: begin
            len2_ff <= len2_ff + prod_ff[LEN2_W-1:0];
         end
         LD_DELTA: begin
            dx_ff <= diff_x;
            dy_ff <= diff_y;
         end
         LD_CR_FIRST: begin
            cr_ff <= prod_ff[CR_W-1:0];
         end
         LD_CR_SUB: begin
            cr_ff <= cr_ff - prod_ff[CR_W-1:0];
         end
         LD_MAG: begin
            mag_ff <= mag_in;
         end
         LD_LIM: begin
            lim_ff <= acc_ff;
         end
         LD_ANCHOR: begin
            anc_x_ff <= rd_x;
            anc_y_ff <= rd_y;
         end
         LD_OUT: begin
            out_x_ff    <= anc_x_ff;
            out_y_ff    <= anc_y_ff;
            out_last_ff <= cmd.out_last;
            out_over_ff <= cmd.out_over;
         end
         default: begin
         end
      endcase
   end

   assign status.zero_chord = (bx_ff == '0) && (by_ff == '0);
   assign status.too_far    = acc_ff > lim_ff;

   assign kept_x     = out_x_ff;
   assign kept_y     = out_y_ff;
   assign last_kept  = out_last_ff;
   assign overflowed = out_over_ff;

endmodule

`default_nettype wire

// File: hw/rtl/polyline_shortcut_prune_core.sv
`default_nettype none

// Channel   Dir  Handshake        Payload
// req       in   valid / ready    point_x, point_y, final_point
// rsp       out  valid / ready    kept_x, kept_y, last_kept, overflowed
// csr_*     in   APB write/read   max_deviation at byte address 0
//
// Points load at one per cycle while req.ready is high; the transfer of the
// flagged last point closes the input until the last kept point is registered.
// Pruning is paced by the single point-store read port and the shared 27x27
// multiplier; a shortcut with a zero-length chord is skipped without the multiplier,
// and any other is checked point by point against the limit until one lies too far.
// A stalled rsp holds the sequencer once its next kept point is due; reset clears it, the point count and drop flag.

module polyline_shortcut_prune_core #(
   parameter int MAX_POINTS = pspr_pkg::MAX_POINTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pspr_req_if.sink                               req,
   pspr_rsp_if.source                             rsp,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pspr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [pspr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [pspr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import pspr_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);

   pspr_cmd_type     cmd;
   pspr_status_type  status;
   logic [IDX_W-1:0] ram_addr;
   logic [DEV_W-1:0] max_dev_ff;
   logic             csr_hit;
   logic             req_ready;
   logic             rsp_valid;

   // The register file is word addressed; the byte offset is ignored.
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_MAX_DEVIATION);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(max_dev_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dev_ff <= DEV_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         max_dev_ff <= csr_pwdata[DEV_W-1:0];
      end
   end

   // The sequencer owns the handshakes and walks the greedy search; the
   // datapath holds the point store, the shared multiplier and the
   // accumulator used for the wide squares.
   pspr_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_final (req.final_point),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd),
      .ram_addr  (ram_addr)
   );

   pspr_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .ram_addr      (ram_addr),
      .point_x       (req.point_x),
      .point_y       (req.point_y),
      .max_deviation (max_dev_ff),
      .status        (status),
      .kept_x        (rsp.kept_x),
      .kept_y        (rsp.kept_y),
      .last_kept     (rsp.last_kept),
      .overflowed    (rsp.overflowed)
   );

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;

   // The transfer of the last point of a path always closes the input.
   a_final_closes_input : assert property (
      @(posedge clock) disable iff (reset)
      req.valid && req.ready && req.final_point |=> !req.ready
   ) else $error("input still open after the last point of a path");

   // The point store is written only on an input transfer.
   a_store_write_on_transfer : assert property (
      @(posedge clock) disable iff (reset)
      cmd.ram_we |-> req.valid && req.ready
   ) else $error("point store written without an input transfer");

   // A kept point is never loaded over a result that is still waiting.
   a_no_result_overwrite : assert property (
      @(posedge clock) disable iff (reset)
      (cmd.ld_op == LD_OUT) |-> (!rsp.valid || rsp.ready)
   ) else $error("output register overwritten before its transfer");

endmodule

`default_nettype wire
